FILE: src/ceilometer_header_parser_assert.svh
// Assertion macros for the ceilometer header parser.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef CEILOMETER_HEADER_PARSER_ASSERT_SVH
`define CEILOMETER_HEADER_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property outside of reset
`define CHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chp: assertion failed");
// Check a property at every edge, reset included
`define CHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("chp: assertion failed");
`else
`define CHP_ASSERT(lbl, prop)
`define CHP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/chp_pkg.sv
// Shared types, status codes and character constants of the header parser.
// No dependencies.
package chp_pkg;

  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_LAST = 4'd12;

  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_L  = 8'h4C;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_5  = 8'h35;
  localparam logic [7:0] CH_9  = 8'h39;

  localparam logic [6:0] CL_BASE  = 7'd101;
  localparam logic [6:0] CL_GROUP = 7'd6;

  localparam logic [7:0] SOH_RESET = 8'd1;
  localparam logic [7:0] STX_RESET = 8'd2;

  // Configuration register indexes
  localparam logic CFG_SOH = 1'b0;
  localparam logic CFG_STX = 1'b1;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_BAD_START     = 4'd1,
    ST_BAD_TYPE      = 4'd2,
    ST_BAD_DIGIT     = 4'd3,
    ST_BAD_CL_FIRST  = 4'd4,
    ST_BAD_CL_SECOND = 4'd5,
    ST_BAD_CT_TAIL   = 4'd6,
    ST_BAD_STX       = 4'd7,
    ST_BAD_CRLF      = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    KIND_CS = 2'd0,
    KIND_CL = 2'd1,
    KIND_CT = 2'd2
  } kind_e;

  // One byte handed from the input register to the checker
  typedef struct packed {
    logic       fire;
    logic [7:0] header_byte;
  } step_t;

  typedef struct packed {
    status_e    status;
    kind_e      message_type;
    logic [7:0] unit_id;
    logic [7:0] os_byte0;
    logic [7:0] os_byte1;
    logic [7:0] os_byte2;
    logic [9:0] message_number;
  } res_t;

endpackage

FILE: src/chp_stream_if.sv
// Valid/ready channels of the header parser: header bytes in, results out.
// No dependencies.
interface chp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink (input valid, input header_byte, output ready);
endinterface

interface chp_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [1:0] message_type;
  logic [7:0] unit_id;
  logic [7:0] os_byte0;
  logic [7:0] os_byte1;
  logic [7:0] os_byte2;
  logic [9:0] message_number;

  modport source (
    output valid, output status, output message_type, output unit_id,
    output os_byte0, output os_byte1, output os_byte2, output message_number,
    input ready
  );
  modport sink (
    input valid, input status, input message_type, input unit_id,
    input os_byte0, input os_byte1, input os_byte2, input message_number,
    output ready
  );
endinterface

FILE: src/chp_in_stage.sv
// Input register of the header parser: holds one header byte beat.
// Depends on chp_pkg.
module chp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    header_byte_i,
  output logic          ready_o,
  input  logic          space_i,
  output chp_pkg::step_t step_o
);
  import chp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       advance;

  // Hand the held byte on whenever the result side has room
  assign advance = valid_q && space_i;
  assign ready_o = !valid_q || advance;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on each accepted beat
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= header_byte_i;
    end
  end

  assign step_o.fire        = advance;
  assign step_o.header_byte = byte_q;

endmodule

FILE: src/chp_parser.sv
// Header checker: position tracking, field stores and per-byte checks.
// Depends on chp_pkg and the assertion macro header.
`include "ceilometer_header_parser_assert.svh"

module chp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  chp_pkg::step_t step_i,
  output logic          emit_o,
  output chp_pkg::res_t  res_o
);
  import chp_pkg::*;

  logic [7:0]       soh_q, stx_q;
  logic [POS_W-1:0] pos_q, pos_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       os0_q, os0_d, os1_q, os1_d, os2_q, os2_d;
  logic [9:0]       num_q, num_d;
  logic             grp_q, grp_d;

  logic [7:0]       b;
  logic [POS_W-1:0] tail;
  logic             emit;
  logic             blank;
  status_e          status;
  logic [9:0]       cs_num;
  logic [2:0]       cl_off;
  logic [6:0]       cl_num;
  logic             is_digit;

  assign b        = step_i.header_byte;
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign cs_num   = 10'(num_q << 3) + 10'(num_q << 1) + {6'd0, b[3:0]};
  assign cl_off   = (b == CH_0) ? 3'd5 : (b[2:0] - 3'd1);
  assign cl_num   = CL_BASE + (grp_q ? CL_GROUP : 7'd0) + {4'd0, cl_off};

  // Last type-dependent position plus one, where STX is due
  always_comb begin
    case (kind_q)
      KIND_CS: tail = 4'd10;
      KIND_CL: tail = 4'd9;
      default: tail = 4'd8;
    endcase
  end

  // Check the byte against its position and update the stores
  always_comb begin
    pos_d  = pos_q + 4'd1;
    kind_d = kind_q;
    id_d   = id_q;
    os0_d  = os0_q;
    os1_d  = os1_q;
    os2_d  = os2_q;
    num_d  = num_q;
    grp_d  = grp_q;
    emit   = 1'b0;
    blank  = 1'b0;
    status = ST_OK;
    unique case (pos_q)
      4'd0: begin
        if (b != soh_q) begin
          emit   = 1'b1;
          blank  = 1'b1;
          status = ST_BAD_START;
        end else begin
          kind_d = KIND_CS;
          id_d   = '0;
          os0_d  = '0;
          os1_d  = '0;
          os2_d  = '0;
          num_d  = '0;
          grp_d  = 1'b0;
        end
      end
      4'd1: begin
        if (b != CH_C) begin
          emit   = 1'b1;
          status = ST_BAD_TYPE;
        end
      end
      4'd2: begin
        case (b)
          CH_S:    kind_d = KIND_CS;
          CH_L:    kind_d = KIND_CL;
          CH_T:    kind_d = KIND_CT;
          default: begin
            emit   = 1'b1;
            status = ST_BAD_TYPE;
          end
        endcase
      end
      4'd3: id_d  = b;
      4'd4: os0_d = b;
      4'd5: os1_d = b;
      4'd6: begin
        if (kind_q == KIND_CT) begin
          if (b != CH_1) begin
            emit   = 1'b1;
            status = ST_BAD_CT_TAIL;
          end
        end else begin
          os2_d = b;
        end
      end
      default: begin
        if (pos_q < tail) begin
          case (kind_q)
            KIND_CS: begin
              if (!is_digit) begin
                emit   = 1'b1;
                status = ST_BAD_DIGIT;
              end else begin
                num_d = cs_num;
              end
            end
            KIND_CL: begin
              if (pos_q == 4'd7) begin
                if (b == CH_1) begin
                  grp_d = 1'b0;
                end else if (b == CH_2) begin
                  grp_d = 1'b1;
                end else begin
                  emit   = 1'b1;
                  status = ST_BAD_CL_FIRST;
                end
              end else if (b == CH_0 || (b >= CH_1 && b <= CH_5)) begin
                num_d = {3'd0, cl_num};
              end else begin
                emit   = 1'b1;
                status = ST_BAD_CL_SECOND;
              end
            end
            default: begin
              if (b != CH_0) begin
                emit   = 1'b1;
                status = ST_BAD_CT_TAIL;
              end
            end
          endcase
        end else if (pos_q == tail) begin
          if (b != stx_q) begin
            emit   = 1'b1;
            status = ST_BAD_STX;
          end
        end else if (pos_q == tail + 4'd1) begin
          if (b != CH_CR) begin
            emit   = 1'b1;
            status = ST_BAD_CRLF;
          end
        end else if (pos_q == tail + 4'd2) begin
          emit = 1'b1;
          if (b != CH_LF) begin
            status = ST_BAD_CRLF;
          end
        end else begin
          pos_d = '0;
        end
      end
    endcase
    // Drop back to waiting for a new header after any result
    if (emit) begin
      pos_d = '0;
    end
  end

  // Build the result from the stores as they stood before this byte, zeroed on a bad start
  always_comb begin
    res_o.status         = status;
    res_o.message_type   = blank ? KIND_CS : kind_q;
    res_o.unit_id        = blank ? 8'd0 : id_q;
    res_o.os_byte0       = blank ? 8'd0 : os0_q;
    res_o.os_byte1       = blank ? 8'd0 : os1_q;
    res_o.os_byte2       = blank ? 8'd0 : os2_q;
    res_o.message_number = blank ? 10'd0 : num_q;
  end

  assign emit_o = step_i.fire && emit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soh_q <= SOH_RESET;
      stx_q <= STX_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SOH) begin
        soh_q <= cfg_data_i;
      end else begin
        stx_q <= cfg_data_i;
      end
    end
  end

  // Advance parse state on each byte beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= KIND_CS;
      id_q   <= '0;
      os0_q  <= '0;
      os1_q  <= '0;
      os2_q  <= '0;
      num_q  <= '0;
      grp_q  <= 1'b0;
    end else if (step_i.fire) begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      id_q   <= id_d;
      os0_q  <= os0_d;
      os1_q  <= os1_d;
      os2_q  <= os2_d;
      num_q  <= num_d;
      grp_q  <= grp_d;
    end
  end

  `CHP_ASSERT(a_emit_rewinds, emit_o |=> pos_q == '0)
  `CHP_ASSERT_ALWAYS(a_pos_range, pos_q <= POS_LAST)
  `CHP_ASSERT(a_bad_start_blank, emit_o && blank |-> res_o.unit_id == '0 && res_o.os_byte0 == '0)

endmodule

FILE: src/chp_out_stage.sv
// Result register of the header parser: holds one result beat until taken.
// Depends on chp_pkg.
module chp_out_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  chp_pkg::res_t res_i,
  output logic         space_o,
  output logic         valid_o,
  input  logic         ready_i,
  output chp_pkg::res_t res_o
);
  import chp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/ceilometer_header_parser.sv
// Ceilometer header parser, top level: input register, checker, result register.
// The byte that causes a result is held in the input register and checked
// combinationally; the result is then registered in the result register.
// Throughput: one header byte per cycle, set by the combinational check between
// the input register and the result register; stalls only while a result waits.
// Reset: asynchronous, clears position, stores and handshake state; SOH and STX
// registers return to 1 and 2.
module ceilometer_header_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  chp_byte_if.sink      hdr_i,
  chp_result_if.source  res_o
);
  import chp_pkg::*;

  step_t step;
  logic  space;
  logic  emit;
  res_t  res_next;
  res_t  res_out;

  chp_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (hdr_i.valid),
    .header_byte_i (hdr_i.header_byte),
    .ready_o       (hdr_i.ready),
    .space_i       (space),
    .step_o        (step)
  );

  chp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .emit_o     (emit),
    .res_o      (res_next)
  );

  chp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res_next),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_out)
  );

  // Drive the result channel payload
  assign res_o.status         = res_out.status;
  assign res_o.message_type   = res_out.message_type;
  assign res_o.unit_id        = res_out.unit_id;
  assign res_o.os_byte0       = res_out.os_byte0;
  assign res_o.os_byte1       = res_out.os_byte1;
  assign res_o.os_byte2       = res_out.os_byte2;
  assign res_o.message_number = res_out.message_number;

endmodule
